// File: design/local_variance_edge_preserving_blur_assert.svh
// Assertion macros for the local variance edge preserving blur checker.
`ifndef LOCAL_VARIANCE_EDGE_PRESERVING_BLUR_ASSERT_SVH
`define LOCAL_VARIANCE_EDGE_PRESERVING_BLUR_ASSERT_SVH

// same-cycle implication
`define LVEPB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LVEPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lvepb_pkg.sv
// Shared types, constants and helpers for the local variance edge preserving blur.
`timescale 1ns / 1ps
`default_nettype none
package lvepb_pkg;

  localparam int WINDOW_DEFAULT    = 5;
  localparam int MAX_WIDTH_DEFAULT = 1024;

  localparam int GEOM_W     = 11;
  localparam int STRENGTH_W = 16;
  localparam int CFG_W      = 16;
  localparam int IDX_W      = 2;
  localparam int RECIP_SH   = 16;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH        = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT       = 2'd1;
  localparam logic [IDX_W-1:0] REG_SMOOTHING_STRENGTH = 2'd2;

  localparam logic [GEOM_W-1:0]     FRAME_WIDTH_RST  = 11'd640;
  localparam logic [GEOM_W-1:0]     FRAME_HEIGHT_RST = 11'd480;
  localparam logic [STRENGTH_W-1:0] STRENGTH_RST     = 16'd25;

  localparam logic [16:0] K_ONE = 17'h10000;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       frame_end;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_POS, S_CMP, S_DRAIN, S_START, S_ROW_Y, S_ROW_Q, S_ROW_S, S_COL,
    S_FLUSH, S_MUL, S_DIV_M, S_DIV_MEAN, S_PREP, S_DIV_K, S_FIN, S_DONE
  } state_t;

  // reflect-101 with a clamp for frames smaller than the window
  function automatic logic signed [15:0] reflect_idx(input logic signed [15:0] i,
                                                     input logic signed [15:0] n);
    logic signed [15:0] t;
    t = i;
    if (t < 16'sd0) t = -t;
    if (t > n - 16'sd1) t = ((n - 16'sd1) <<< 1) - t;
    if (t < 16'sd0) t = 16'sd0;
    if (t > n - 16'sd1) t = n - 16'sd1;
    return t;
  endfunction

endpackage
`default_nettype wire

// File: design/lvepb_line_mem.sv
// Line store: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lvepb_line_mem #(
  parameter int DEPTH = 5120,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/lvepb_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lvepb_div #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 23
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic [NUM_W-1:0]     quot,
  output lvepb_pkg::div_stat_t stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] qr;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dr;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, qr[NUM_W-1]};
  assign fits  = trial >= {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      qr  <= num;
      rem <= '0;
      dr  <= den;
    end else if (busy) begin
      qr  <= {qr[NUM_W-2:0], fits};
      rem <= fits ? DEN_W'(trial - {1'b0, dr}) : trial[DEN_W-1:0];
    end
  end

  assign quot      = qr;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

// File: design/local_variance_edge_preserving_blur.sv
// Top level: local variance (Lee) edge preserving blur over a BGR raster stream.
//
// A push with no result goes through accept, position and compare. A push that produces a
// result then walks the window out of the line store, one read per cycle along each row,
// with the start and flush steps, and filters the three channels in turn: square-mean and
// mean arithmetic by reciprocal multiplication, then the shared bit-serial divider for the
// gain (skipped when the gain divisor is 0), and the result register waits on out_ready. A
// drain that releases a pixel has one drain step in place of position and compare; a drain
// with nothing pending is only accepted. The gain divider and the single read port of the
// line store dominate this work; a new push is taken only once the last one is finished.
// Outputs lag by WINDOW/2 lines plus WINDOW/2 pixels; once a frame is complete, drain beats
// release the rest. Configure only while idle.
`timescale 1ns / 1ps
`default_nettype none
module local_variance_edge_preserving_blur #(
  parameter int WINDOW    = lvepb_pkg::WINDOW_DEFAULT,
  parameter int MAX_WIDTH = lvepb_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lvepb_pkg::in_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lvepb_pkg::out_t             out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lvepb_pkg::IDX_W-1:0] cfg_index,
  input  logic [lvepb_pkg::CFG_W-1:0] cfg_data
);

  localparam int GW      = lvepb_pkg::GEOM_W;
  localparam int RADIUS  = WINDOW / 2;
  localparam int SPAN    = 2 * RADIUS + 1;
  localparam int AREA    = SPAN * SPAN;
  localparam int SLOT_W  = $clog2(SPAN);
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int AW      = $clog2(SPAN * MAX_WIDTH);
  localparam int SUM_W   = $clog2(AREA * 255 + 1);
  localparam int SQ_W    = $clog2(AREA * 65025 + 1);
  localparam int SA_W    = lvepb_pkg::STRENGTH_W + $clog2(AREA + 1);
  localparam int DEN_W   = ((SQ_W > SA_W) ? SQ_W : SA_W) + 1;
  localparam int NUM_W   = (2 * SUM_W > SQ_W + 16) ? 2 * SUM_W : SQ_W + 16;
  localparam int POS_W   = 2 * GW + 1;
  localparam int RECIP_W = lvepb_pkg::RECIP_SH + 1;
  localparam int RECIP   = ((1 << lvepb_pkg::RECIP_SH) + SPAN - 1) / SPAN;
  localparam int QW      = GW + RECIP_W;
  localparam int SSQ_W   = 2 * SUM_W;
  localparam int RA_SH   = 32;
  localparam int PROD_W  = SSQ_W + RA_SH;
  localparam logic [RA_SH-1:0] RECIP_A = RA_SH'((64'd1 << RA_SH) / 64'(AREA));

  lvepb_pkg::state_t state, state_next;

  logic [GW-1:0]     frame_width, frame_height;
  logic [15:0]       smoothing_strength;
  logic [GW-1:0]     w_eff, h_eff;

  logic [GW-1:0]     in_row, out_row, fr;
  logic [CW-1:0]     in_col, out_col, fc;
  logic [SLOT_W-1:0] in_slot;
  logic              pending, out_last;
  logic [POS_W-1:0]  lin, lout;

  logic [GW-1:0]     in_row_eff, out_row_eff;
  logic [CW-1:0]     in_col_eff, out_col_eff;
  logic [SLOT_W-1:0] in_slot_eff;
  logic              in_col_end, in_row_end, out_col_end, out_row_end, emit;

  logic [SLOT_W-1:0] iy, ix, slot;
  logic [GW-1:0]     y_reg, q_reg;
  logic signed [15:0] y_calc, col_ref;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [23:0]       rdata;
  logic              rd_valid, rd_center;

  logic [SUM_W-1:0]  acc_s [3];
  logic [SQ_W-1:0]   acc_q [3];
  logic [7:0]        pix_p [3];
  logic [7:0]        res   [3];
  logic [1:0]        ch;

  logic [SSQ_W-1:0]   ssq;
  logic [SA_W-1:0]    sa;
  logic [SSQ_W-1:0]   m_est, m_rem;
  logic [SUM_W-1:0]   mean_est, mean_rem;
  logic               m_fix, mean_fix;
  logic [SQ_W-1:0]    m_reg, d_calc;
  logic [7:0]         mean;
  logic [SQ_W-1:0]    d_reg;
  logic [DEN_W-1:0]   den_reg;
  logic [16:0]        k_reg, k_comp;
  logic [25:0]        fin;

  logic               launched, div_start;
  logic [NUM_W-1:0]   div_num, div_quot;
  logic [DEN_W-1:0]   div_den;
  lvepb_pkg::div_stat_t div_stat;

  // geometry
  always_comb begin
    if (frame_width == '0) w_eff = GW'(1);
    else if (int'(frame_width) > MAX_WIDTH) w_eff = GW'(MAX_WIDTH);
    else w_eff = frame_width;
    h_eff = (frame_height == '0) ? GW'(1) : frame_height;
  end

  always_comb begin
    in_row_eff  = (in_row >= h_eff) ? '0 : in_row;
    in_slot_eff = (in_row >= h_eff) ? '0 : in_slot;
    in_col_eff  = (int'(in_col) >= int'(w_eff)) ? '0 : in_col;
    out_row_eff = (out_row >= h_eff) ? '0 : out_row;
    out_col_eff = (int'(out_col) >= int'(w_eff)) ? '0 : out_col;
    in_col_end  = int'(in_col) + 1 >= int'(w_eff);
    in_row_end  = int'(in_row) + 1 >= int'(h_eff);
    out_col_end = int'(out_col) + 1 >= int'(w_eff);
    out_row_end = int'(out_row) + 1 >= int'(h_eff);
    emit        = lin >= lout;
  end

  assign y_calc = lvepb_pkg::reflect_idx(signed'(16'(fr)) + signed'(16'(iy))
                                         - signed'(16'(RADIUS)), signed'(16'(h_eff)));
  assign col_ref = lvepb_pkg::reflect_idx(signed'(16'(fc)) + signed'(16'(ix))
                                          - signed'(16'(RADIUS)), signed'(16'(w_eff)));

  // reciprocal estimates are low by at most one; one compare fixes them
  assign m_rem    = ssq - SSQ_W'(m_est * SSQ_W'(AREA));
  assign m_fix    = m_rem >= SSQ_W'(AREA);
  assign mean_rem = acc_s[ch] - SUM_W'(mean_est * SUM_W'(AREA));
  assign mean_fix = mean_rem >= SUM_W'(AREA);

  assign d_calc = (acc_q[ch] >= m_reg) ? SQ_W'(acc_q[ch] - m_reg) : '0;
  assign k_comp = lvepb_pkg::K_ONE - k_reg;
  assign fin    = 26'(k_comp) * 26'(mean) + 26'(k_reg) * 26'(pix_p[ch]);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lvepb_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.operation == lvepb_pkg::OP_PUSH) state_next = lvepb_pkg::S_POS;
          else if (pending) state_next = lvepb_pkg::S_DRAIN;
        end
      end
      lvepb_pkg::S_POS:   state_next = lvepb_pkg::S_CMP;
      lvepb_pkg::S_CMP:   state_next = emit ? lvepb_pkg::S_START : lvepb_pkg::S_IDLE;
      lvepb_pkg::S_DRAIN: state_next = lvepb_pkg::S_START;
      lvepb_pkg::S_START: state_next = lvepb_pkg::S_ROW_Y;
      lvepb_pkg::S_ROW_Y: state_next = lvepb_pkg::S_ROW_Q;
      lvepb_pkg::S_ROW_Q: state_next = lvepb_pkg::S_ROW_S;
      lvepb_pkg::S_ROW_S: state_next = lvepb_pkg::S_COL;
      lvepb_pkg::S_COL: begin
        if (ix == SLOT_W'(SPAN - 1)) begin
          state_next = (iy == SLOT_W'(SPAN - 1)) ? lvepb_pkg::S_FLUSH : lvepb_pkg::S_ROW_Y;
        end
      end
      lvepb_pkg::S_FLUSH: state_next = lvepb_pkg::S_MUL;
      lvepb_pkg::S_MUL:   state_next = lvepb_pkg::S_DIV_M;
      lvepb_pkg::S_DIV_M: state_next = lvepb_pkg::S_DIV_MEAN;
      lvepb_pkg::S_DIV_MEAN: state_next = lvepb_pkg::S_PREP;
      lvepb_pkg::S_PREP:  state_next = lvepb_pkg::S_DIV_K;
      lvepb_pkg::S_DIV_K: begin
        if (den_reg == '0 || div_stat.done) state_next = lvepb_pkg::S_FIN;
      end
      lvepb_pkg::S_FIN:   state_next = (ch == 2'd2) ? lvepb_pkg::S_DONE : lvepb_pkg::S_MUL;
      lvepb_pkg::S_DONE:  if (!out_valid || out_ready) state_next = lvepb_pkg::S_IDLE;
      default:            state_next = lvepb_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    we        = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DEN_W'(AREA);
    case (state)
      lvepb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        we       = in_valid && (in_data.operation == lvepb_pkg::OP_PUSH);
      end
      lvepb_pkg::S_DIV_K: begin
        div_start = !launched && (den_reg != '0);
        div_num   = NUM_W'({d_reg, 16'h0000});
        div_den   = den_reg;
      end
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign waddr = AW'(AW'(in_slot_eff) * AW'(MAX_WIDTH)) + AW'(in_col_eff);
  assign raddr = AW'(AW'(slot) * AW'(MAX_WIDTH)) + AW'(col_ref[CW-1:0]);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= lvepb_pkg::S_IDLE;
      frame_width        <= lvepb_pkg::FRAME_WIDTH_RST;
      frame_height       <= lvepb_pkg::FRAME_HEIGHT_RST;
      smoothing_strength <= lvepb_pkg::STRENGTH_RST;
      in_row             <= '0;
      in_col             <= '0;
      in_slot            <= '0;
      out_row            <= '0;
      out_col            <= '0;
      pending            <= 1'b0;
      out_valid          <= 1'b0;
      launched           <= 1'b0;
      rd_valid           <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == lvepb_pkg::S_COL);
      if (div_start) launched <= 1'b1;
      else if (div_stat.done) launched <= 1'b0;
      if (state == lvepb_pkg::S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (cfg_valid) begin
        case (cfg_index)
          lvepb_pkg::REG_FRAME_WIDTH:        frame_width <= cfg_data[GW-1:0];
          lvepb_pkg::REG_FRAME_HEIGHT:       frame_height <= cfg_data[GW-1:0];
          lvepb_pkg::REG_SMOOTHING_STRENGTH: smoothing_strength <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        lvepb_pkg::S_IDLE: begin
          if (in_valid) begin
            in_row  <= in_row_eff;
            in_col  <= in_col_eff;
            in_slot <= in_slot_eff;
            if (in_data.operation == lvepb_pkg::OP_PUSH && pending) begin
              pending <= 1'b0;
              out_row <= '0;
              out_col <= '0;
            end else begin
              out_row <= out_row_eff;
              out_col <= out_col_eff;
            end
          end
        end
        lvepb_pkg::S_DRAIN: begin
          out_col <= out_col_end ? '0 : CW'(out_col + 1'b1);
          if (out_col_end) out_row <= out_row_end ? '0 : GW'(out_row + 1'b1);
          if (out_col_end && out_row_end) pending <= 1'b0;
        end
        lvepb_pkg::S_CMP: begin
          in_col <= in_col_end ? '0 : CW'(in_col + 1'b1);
          if (in_col_end) begin
            in_row  <= in_row_end ? '0 : GW'(in_row + 1'b1);
            in_slot <= (in_row_end || in_slot == SLOT_W'(SPAN - 1)) ? '0
                       : SLOT_W'(in_slot + 1'b1);
          end
          if (emit) begin
            out_col <= out_col_end ? '0 : CW'(out_col + 1'b1);
            if (out_col_end) out_row <= out_row_end ? '0 : GW'(out_row + 1'b1);
          end
          if (in_col_end && in_row_end && !(emit && out_col_end && out_row_end)) begin
            pending <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      lvepb_pkg::S_POS: begin
        lin  <= POS_W'(in_row) * POS_W'(w_eff) + POS_W'(in_col);
        lout <= POS_W'(out_row) * POS_W'(w_eff) + POS_W'(out_col)
                + POS_W'(RADIUS) * POS_W'(w_eff) + POS_W'(RADIUS);
      end
      lvepb_pkg::S_CMP: begin
        fr       <= out_row;
        fc       <= out_col;
        out_last <= out_col_end && out_row_end;
      end
      lvepb_pkg::S_DRAIN: begin
        fr       <= out_row;
        fc       <= out_col;
        out_last <= out_col_end && out_row_end;
      end
      lvepb_pkg::S_START: begin
        iy <= '0;
        ix <= '0;
      end
      lvepb_pkg::S_ROW_Y: y_reg <= y_calc[GW-1:0];
      lvepb_pkg::S_ROW_Q: begin
        q_reg <= GW'((QW'(y_reg) * QW'(RECIP)) >> lvepb_pkg::RECIP_SH);
      end
      lvepb_pkg::S_ROW_S: begin
        slot <= SLOT_W'(y_reg - GW'(q_reg * GW'(SPAN)));
        ix   <= '0;
      end
      lvepb_pkg::S_COL: begin
        ix <= SLOT_W'(ix + 1'b1);
        if (ix == SLOT_W'(SPAN - 1)) iy <= SLOT_W'(iy + 1'b1);
      end
      lvepb_pkg::S_FLUSH: ch <= '0;
      lvepb_pkg::S_MUL: begin
        ssq <= acc_s[ch] * acc_s[ch];
        sa  <= SA_W'(smoothing_strength * SA_W'(AREA));
      end
      lvepb_pkg::S_DIV_M: begin
        m_est    <= SSQ_W'((PROD_W'(ssq) * PROD_W'(RECIP_A)) >> RA_SH);
        mean_est <= SUM_W'((PROD_W'(acc_s[ch]) * PROD_W'(RECIP_A)) >> RA_SH);
      end
      lvepb_pkg::S_DIV_MEAN: m_reg <= SQ_W'(m_est + SSQ_W'(m_fix));
      lvepb_pkg::S_PREP: begin
        mean    <= 8'(mean_est + SUM_W'(mean_fix));
        d_reg   <= d_calc;
        den_reg <= DEN_W'(d_calc) + DEN_W'(sa);
      end
      lvepb_pkg::S_DIV_K: begin
        if (den_reg == '0) k_reg <= '0;
        else if (div_stat.done) k_reg <= div_quot[16:0];
      end
      lvepb_pkg::S_FIN: begin
        res[ch] <= fin[23:16];
        ch      <= ch + 1'b1;
      end
      lvepb_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_data.out_blue  <= res[0];
          out_data.out_green <= res[1];
          out_data.out_red   <= res[2];
          out_data.frame_end <= out_last;
        end
      end
      default: ;
    endcase

    rd_center <= (state == lvepb_pkg::S_COL) && (iy == SLOT_W'(RADIUS))
                 && (ix == SLOT_W'(RADIUS));
    for (int c = 0; c < 3; c++) begin
      if (state == lvepb_pkg::S_START) begin
        acc_s[c] <= '0;
        acc_q[c] <= '0;
      end else if (rd_valid) begin
        acc_s[c] <= acc_s[c] + SUM_W'(rdata[8*c +: 8]);
        acc_q[c] <= acc_q[c] + SQ_W'(16'(rdata[8*c +: 8]) * 16'(rdata[8*c +: 8]));
        if (rd_center) pix_p[c] <= rdata[8*c +: 8];
      end
    end
  end

  lvepb_line_mem #(
    .DEPTH(SPAN * MAX_WIDTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({in_data.in_red, in_data.in_green, in_data.in_blue}),
    .raddr(raddr),
    .rdata(rdata)
  );

  lvepb_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .quot (div_quot),
    .stat (div_stat)
  );

endmodule
`default_nettype wire

// File: design/lvepb_checker.sv
// Port-level checker for the blur top level, bound in below.
`timescale 1ns / 1ps
`default_nettype none
`include "local_variance_edge_preserving_blur_assert.svh"
module lvepb_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire lvepb_pkg::in_t              in_data,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire lvepb_pkg::out_t             out_data,
  input wire logic                        cfg_valid,
  input wire logic                        cfg_ready,
  input wire logic [lvepb_pkg::IDX_W-1:0] cfg_index,
  input wire logic [lvepb_pkg::CFG_W-1:0] cfg_data
);

  `LVEPB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")
  `LVEPB_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config beat refused")
  `LVEPB_ASSERT_NEXT(a_push_busy, in_valid && in_ready && !in_data.operation, !in_ready, "input taken during push handling")
  `LVEPB_ASSERT_NOW(a_result_busy, $rose(out_valid), $past(!in_ready), "result appeared while idle")

endmodule

bind local_variance_edge_preserving_blur lvepb_checker u_checker (.*);
`default_nettype wire
